// ===== hw/rtl/mnpg_pkg.sv =====
package mnpg_pkg;

  // stack geometry
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned VEL_W       = 7;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam int unsigned COUNT_OUT_MAX = (2 ** COUNT_OUT_W) - 1;

  localparam logic [NOTE_W-1:0] BUTTON_NOTE    = NOTE_W'(60);
  localparam logic [VEL_W-1:0]  HOLD_THRESHOLD = VEL_W'(64);

  // event codes
  typedef enum logic [ACT_W-1:0] {
    ACT_NOTE_ON        = 3'd0,
    ACT_NOTE_OFF       = 3'd1,
    ACT_PEDAL          = 3'd2,
    ACT_HOLD_TOGGLE    = 3'd3,
    ACT_BUTTON_PRESS   = 3'd4,
    ACT_BUTTON_RELEASE = 3'd5
  } action_e;

  // request into the note stack
  typedef struct packed {
    logic              valid;
    logic              is_release;
    logic [NOTE_W-1:0] note;
  } stack_req_t;

  // answer from the note stack
  typedef struct packed {
    logic              done;
    logic              top_valid;
    logic [NOTE_W-1:0] top_note;
    logic [CNT_W-1:0]  count;
  } stack_rsp_t;

  // stack fill as reported on the result, saturated
  function automatic logic [COUNT_OUT_W-1:0] count_out(logic [CNT_W-1:0] c);
    if (32'(c) > COUNT_OUT_MAX) begin
      return COUNT_OUT_W'(COUNT_OUT_MAX);
    end
    return COUNT_OUT_W'(c);
  endfunction

endpackage

// ===== hw/rtl/mnpg_stack.sv =====
module mnpg_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mnpg_pkg::stack_req_t req_i,
  output mnpg_pkg::stack_rsp_t rsp_o
);
  import mnpg_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_WALK     = 2'd1;
  localparam logic [1:0] S_TOP_RD   = 2'd2;
  localparam logic [1:0] S_TOP_WAIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              is_rel_q, is_rel_d;
  logic [NOTE_W-1:0] note_q, note_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              found_q, found_d;

  // note memory, one write and one registered read port
  logic [NOTE_W-1:0] mem_q [STACK_DEPTH];
  logic [NOTE_W-1:0] rd_data_q;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [NOTE_W-1:0] mem_wdata;

  logic issue;
  logic hit;
  logic walk_end;
  logic add_note;

  // walk helpers
  assign issue    = (state_q == S_WALK) && (rd_idx_q < cnt_q);
  assign hit      = (state_q == S_WALK) && rd_vld_q && !found_q && (rd_data_q == note_q);
  assign walk_end = (state_q == S_WALK) &&
                    ((!is_rel_q && hit) || ((rd_idx_q == cnt_q) && !rd_vld_q));
  assign add_note = walk_end && !is_rel_q && !hit && (cnt_q < CNT_W'(STACK_DEPTH));

  // sequencer
  always_comb begin
    state_d   = state_q;
    is_rel_d  = is_rel_q;
    note_d    = note_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    rd_vld_d  = 1'b0;
    found_d   = found_q;
    mem_re    = 1'b0;
    mem_raddr = rd_idx_q[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_q - IDX_W'(1);
    mem_wdata = rd_data_q;
    rsp_o.done      = 1'b0;
    rsp_o.top_valid = (cnt_q != '0);
    rsp_o.top_note  = rd_data_q;
    rsp_o.count     = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          is_rel_d = req_i.is_release;
          note_d   = req_i.note;
          rd_idx_d = '0;
          found_d  = 1'b0;
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        // stream reads in index order, compare one entry per cycle
        if (issue) begin
          mem_re    = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
          rd_vld_d  = 1'b1;
        end
        if (hit) begin
          found_d = 1'b1;
        end
        // after the removed entry, every arriving entry moves down one place
        if (is_rel_q && found_q && rd_vld_q) begin
          mem_we = 1'b1;
        end
        if (add_note) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IDX_W-1:0];
          mem_wdata = note_q;
          cnt_d     = cnt_q + CNT_W'(1);
        end
        if (walk_end) begin
          if (is_rel_q) begin
            if (found_q) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
            state_d = S_TOP_RD;
          end else begin
            rsp_o.done = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_TOP_RD: begin
        if (cnt_q == '0) begin
          rsp_o.done = 1'b1;
          state_d    = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(cnt_q - CNT_W'(1));
          state_d   = S_TOP_WAIT;
        end
      end
      S_TOP_WAIT: begin
        rsp_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      is_rel_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      is_rel_q <= is_rel_d;
    end
  end

  // walk payload
  always_ff @(posedge clk_i) begin
    note_q    <= note_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
  end

  // memory array
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

endmodule

// ===== hw/rtl/mono_note_priority_gate_core.sv =====
// Last-note priority tracker and gate for a monophonic voice. Each item is one
// control event (note on, note off, pedal, hold toggle, gate button press or
// release) and yields one result item with the state after the event: target
// note, sounding note, gate, hold latch, last velocity and stack fill. Held notes
// sit in a 16-entry memory with a registered read; note on and note off walk it
// one entry per cycle through that read port. One item is in work at a time;
// the next item is taken as soon as the previous result sits in the output
// register, even if that result has not been taken yet.
module mono_note_priority_gate_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mnpg_pkg::ACT_W-1:0]         action_i,
  input  logic [mnpg_pkg::NOTE_W-1:0]        note_number_i,
  input  logic [mnpg_pkg::VEL_W-1:0]         amount_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mnpg_pkg::NOTE_W-1:0]        target_note_o,
  output logic                               note_held_o,
  output logic [mnpg_pkg::NOTE_W-1:0]        held_note_o,
  output logic                               gate_open_o,
  output logic                               hold_active_o,
  output logic [mnpg_pkg::VEL_W-1:0]         last_velocity_o,
  output logic [mnpg_pkg::COUNT_OUT_W-1:0]   stack_count_o
);
  import mnpg_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_WALK = 2'd1;
  localparam logic [1:0] T_EMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              is_rel_q, is_rel_d;
  logic [NOTE_W-1:0] note_q, note_d;
  logic [VEL_W-1:0]  amt_q, amt_d;

  // voice state
  logic [NOTE_W-1:0] cur_note_q, cur_note_d;
  logic              cur_valid_q, cur_valid_d;
  logic [NOTE_W-1:0] aim_q, aim_d;
  logic              gate_q, gate_d;
  logic              hold_q, hold_d;
  logic [VEL_W-1:0]  vel_q, vel_d;

  // result register
  logic                   out_valid_q;
  logic [NOTE_W-1:0]      out_target_q;
  logic                   out_held_q;
  logic [NOTE_W-1:0]      out_note_q;
  logic                   out_gate_q;
  logic                   out_hold_q;
  logic [VEL_W-1:0]       out_vel_q;
  logic [COUNT_OUT_W-1:0] out_count_q;
  logic                   out_load;

  stack_req_t stack_req;
  stack_rsp_t stack_rsp;
  logic       pedal_on;

  mnpg_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stack_req),
    .rsp_o  (stack_rsp)
  );

  assign in_ready_o = (state_q == T_IDLE);
  assign pedal_on   = (amount_i >= HOLD_THRESHOLD);
  assign out_load   = (state_q == T_EMIT) && (!out_valid_q || out_ready_i);

  // event decode and voice update
  always_comb begin
    state_d     = state_q;
    is_rel_d    = is_rel_q;
    note_d      = note_q;
    amt_d       = amt_q;
    cur_note_d  = cur_note_q;
    cur_valid_d = cur_valid_q;
    aim_d       = aim_q;
    gate_d      = gate_q;
    hold_d      = hold_q;
    vel_d       = vel_q;
    stack_req   = '0;
    stack_req.note = note_number_i;

    unique case (state_q)
      T_IDLE: begin
        if (in_valid_i) begin
          note_d  = note_number_i;
          amt_d   = amount_i;
          state_d = T_EMIT;
          unique case (action_i)
            ACT_NOTE_ON, ACT_NOTE_OFF: begin
              // a note on with zero velocity is a note off
              stack_req.valid      = 1'b1;
              stack_req.is_release = (action_i == ACT_NOTE_OFF) || (amount_i == '0);
              is_rel_d             = stack_req.is_release;
              state_d              = T_WALK;
            end
            ACT_PEDAL: begin
              hold_d = pedal_on;
              if (!pedal_on && !cur_valid_q) begin
                gate_d = 1'b0;
              end
            end
            ACT_HOLD_TOGGLE: begin
              hold_d = !hold_q;
              if (hold_q && !cur_valid_q) begin
                gate_d = 1'b0;
              end
            end
            ACT_BUTTON_PRESS: begin
              if (!cur_valid_q) begin
                aim_d = BUTTON_NOTE;
              end
              gate_d = 1'b1;
            end
            ACT_BUTTON_RELEASE: begin
              if (!hold_q && !cur_valid_q) begin
                gate_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      T_WALK: begin
        if (stack_rsp.done) begin
          state_d = T_EMIT;
          if (!is_rel_q) begin
            cur_note_d  = note_q;
            cur_valid_d = 1'b1;
            aim_d       = note_q;
            vel_d       = amt_q;
            gate_d      = 1'b1;
          end else if (stack_rsp.top_valid) begin
            // fall back to the newest remaining note
            cur_note_d  = stack_rsp.top_note;
            cur_valid_d = 1'b1;
            aim_d       = stack_rsp.top_note;
          end else begin
            cur_valid_d = 1'b0;
            if (!hold_q) begin
              gate_d = 1'b0;
            end
          end
        end
      end
      T_EMIT: begin
        if (out_load) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // control and voice registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      is_rel_q    <= 1'b0;
      cur_note_q  <= '0;
      cur_valid_q <= 1'b0;
      aim_q       <= BUTTON_NOTE;
      gate_q      <= 1'b0;
      hold_q      <= 1'b0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_rel_q    <= is_rel_d;
      cur_note_q  <= cur_note_d;
      cur_valid_q <= cur_valid_d;
      aim_q       <= aim_d;
      gate_q      <= gate_d;
      hold_q      <= hold_d;
      vel_q       <= vel_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    note_q <= note_d;
    amt_q  <= amt_d;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_target_q <= aim_q;
      out_held_q   <= cur_valid_q;
      out_note_q   <= cur_valid_q ? cur_note_q : '0;
      out_gate_q   <= gate_q;
      out_hold_q   <= hold_q;
      out_vel_q    <= vel_q;
      out_count_q  <= count_out(stack_rsp.count);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign target_note_o   = out_target_q;
  assign note_held_o     = out_held_q;
  assign held_note_o     = out_note_q;
  assign gate_open_o     = out_gate_q;
  assign hold_active_o   = out_hold_q;
  assign last_velocity_o = out_vel_q;
  assign stack_count_o   = out_count_q;

endmodule

// ===== hw/rtl/mnpg_checker.sv =====
module mnpg_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [mnpg_pkg::ACT_W-1:0]         action_i,
  input logic [mnpg_pkg::NOTE_W-1:0]        note_number_i,
  input logic [mnpg_pkg::VEL_W-1:0]         amount_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [mnpg_pkg::NOTE_W-1:0]        target_note_o,
  input logic                               note_held_o,
  input logic [mnpg_pkg::NOTE_W-1:0]        held_note_o,
  input logic                               gate_open_o,
  input logic                               hold_active_o,
  input logic [mnpg_pkg::VEL_W-1:0]         last_velocity_o,
  input logic [mnpg_pkg::COUNT_OUT_W-1:0]   stack_count_o
);
  import mnpg_pkg::*;

  // a stalled result item keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_note_o) &&
    $stable(held_note_o) && $stable(stack_count_o) && $stable(gate_open_o))
    else $error("result item changed while stalled");

  // a sounding note always keeps the gate open
  a_gate_with_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && note_held_o |-> gate_open_o)
    else $error("note sounds with gate closed");

  // the oscillator aims at the sounding note
  a_aim_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && note_held_o |-> target_note_o == held_note_o)
    else $error("target differs from sounding note");

  // an empty stack leaves no note sounding
  a_empty_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stack_count_o == '0 |-> !note_held_o && held_note_o == '0)
    else $error("note sounds with empty stack");

endmodule

bind mono_note_priority_gate_core mnpg_checker u_mnpg_checker (.*);
